### rtl/dug_pkg.sv
// Shared types and constants of the utilization governor.
`timescale 1ns / 1ps
package dug_pkg;
	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  cpu_index;
		logic [7:0]  util_percent;
		logic [47:0] now_us;
		logic [5:0]  level_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  cpu_out;
		logic [21:0] freq_khz;
		logic        evaluated;
		logic        changed;
		logic [31:0] switch_count;
		logic [31:0] up_count;
		logic [31:0] down_count;
		logic [47:0] freq_sum_khz;
		logic [39:0] energy_centi;
		logic [31:0] level_exit_count;
		logic        last;
	} out_item_t;

	// Per-CPU record held in the CPU memory; frequency is kept as a level code.
	typedef struct packed {
		logic [5:0]  lvl;
		logic [6:0]  util;
		logic [47:0] last_eval;
		logic [31:0] switches;
		logic [31:0] ups;
		logic [31:0] downs;
		logic [47:0] freq_sum;
		logic [39:0] energy;
	} cpu_rec_t;

	localparam int CpuRecW = $bits(cpu_rec_t);

	localparam logic [1:0] OP_UTIL = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_UP = 3'd1;
	localparam logic [2:0] CFG_DOWN = 3'd2;
	localparam logic [2:0] CFG_THR = 3'd3;
	localparam logic [2:0] CFG_BOOST = 3'd4;
	localparam logic [2:0] CFG_ACTIVE = 3'd5;

	localparam logic [1:0] MODE_SAVE = 2'd2;
	localparam logic [5:0] LVL_MAX = 6'd32;
	localparam logic [5:0] LVL_SAVE = 6'd22;

	// Target level (frequency/100 MHz - 8) from utilization, before the powersave cap.
	function automatic logic [5:0] target_level(input logic [6:0] u, input logic [6:0] thr,
			input logic boost);
		logic [15:0] t;
		begin
			// u*40000 rounded to 100000 is floor(u*2/5); low formula adds 10 percent.
			if (u >= thr) t = 16'(u) * 16'd2 + (boost ? 16'd5 : 16'd0);
			else t = (16'(u) + 16'd10) * 16'd2;
			// Multiplying by 205/1024 is an exact floor division by 5 over this range.
			t = (t * 16'd205) >> 10;
			if (t < 16'd8) t = 16'd8;
			if (t > 16'd40) t = 16'd40;
			target_level = 6'(t - 16'd8);
		end
	endfunction

	function automatic logic [21:0] lvl_to_khz(input logic [5:0] l);
		lvl_to_khz = 22'((27'(l) + 27'd8) * 27'd100000);
	endfunction
endpackage

### rtl/dug_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module dug_ram #(
	parameter int Width = 8,
	parameter int Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/dvfs_util_governor_core.sv
// Top level of the utilization governor.
`timescale 1ns / 1ps
// Per-CPU utilization governor. Each request is handled by a sequencer around two
// memories: one record per CPU and one exit counter per CPU and level. A util
// update or a statistics read passes through accept (idle), record read, evaluate,
// write back and output; a tick walks record read, evaluate, write back and output
// once per managed CPU, doing the read-modify-write of the CPU record memory and
// the exit counter memory. An output stall holds the result in the output state.
// After reset a clearing pass sweeps both memories while no request is taken.
// Results leave through an output register; the next request waits until the
// current one's last result has gone.
module dvfs_util_governor_core #(
	parameter int NUM_CPUS = 8,
	parameter int NUM_LEVELS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  dug_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output dug_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);
	import dug_pkg::*;

	localparam int CpuW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int ExDepth = NUM_CPUS * 64;
	localparam int ExW = $clog2(ExDepth);
	localparam int ClrW = $clog2(ExDepth + 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_CALC  = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic [19:0] up_lim_q, down_lim_q;
	logic [6:0] thr_q;
	logic boost_q;
	logic [3:0] active_q;
	in_item_t req_q;
	logic [CpuW-1:0] cpu_q;
	logic [ClrW-1:0] clr_q;
	logic [3:0] n_mng;

	always_comb begin
		n_mng = active_q;
		if (n_mng > 4'd8) n_mng = 4'd8;
		if (32'(n_mng) > NUM_CPUS) n_mng = 4'(NUM_CPUS);
	end

	// Memories
	logic cpu_we, ex_we;
	logic [CpuW-1:0] cpu_waddr, cpu_raddr;
	cpu_rec_t cpu_wdata, cpu_rdata;
	logic [ExW-1:0] ex_waddr, ex_raddr;
	logic [31:0] ex_wdata, ex_rdata;

	dug_ram #(.Width(CpuRecW), .Depth(1 << CpuW)) u_cpu_ram (
		.clk(clk), .we(cpu_we), .waddr(cpu_waddr), .wdata(cpu_wdata),
		.raddr(cpu_raddr), .rdata(cpu_rdata));
	dug_ram #(.Width(32), .Depth(ExDepth)) u_ex_ram (
		.clk(clk), .we(ex_we), .waddr(ex_waddr), .wdata(ex_wdata),
		.raddr(ex_raddr), .rdata(ex_rdata));

	// Evaluation path, registered in READ
	cpu_rec_t rec_s1;
	logic ev_s1, ch_s1, up_s1;
	logic [5:0] tgt_s1;
	logic [47:0] dt;
	logic [19:0] lim;
	logic [5:0] tl;
	logic lvl_ok;
	logic do_ev;
	cpu_rec_t rec_in;

	assign dt = req_q.now_us - cpu_rdata.last_eval;
	assign lim = (req_q.opcode == OP_TICK) ? down_lim_q : up_lim_q;
	assign do_ev = (req_q.opcode != OP_READ) && (dt >= 48'(lim));

	always_comb begin
		rec_in = cpu_rdata;
		if (req_q.opcode == OP_UTIL)
			rec_in.util = req_q.util_percent > 8'd100 ? 7'd100 : req_q.util_percent[6:0];
		if (do_ev) rec_in.last_eval = req_q.now_us;
	end

	always_comb begin
		tl = target_level(rec_in.util, thr_q, boost_q);
		if (mode_q == MODE_SAVE && tl > LVL_SAVE) tl = LVL_SAVE;
	end
	assign lvl_ok = 32'(req_q.level_index) < NUM_LEVELS;

	cpu_rec_t new_rec;
	logic [6:0] k;
	logic [13:0] kk;
	always_comb begin
		k = 7'(tgt_s1) + 7'd8;
		kk = 14'(k) * 14'(k);
		new_rec = rec_s1;
		if (ch_s1) begin
			new_rec.lvl = tgt_s1;
			new_rec.switches = &rec_s1.switches ? rec_s1.switches : rec_s1.switches + 32'd1;
			if (up_s1) new_rec.ups = &rec_s1.ups ? rec_s1.ups : rec_s1.ups + 32'd1;
			else new_rec.downs = &rec_s1.downs ? rec_s1.downs : rec_s1.downs + 32'd1;
			new_rec.freq_sum = (49'(rec_s1.freq_sum) + 49'(lvl_to_khz(tgt_s1))) > 49'hFFFFFFFFFFFF
				? 48'hFFFFFFFFFFFF : rec_s1.freq_sum + 48'(lvl_to_khz(tgt_s1));
			new_rec.energy = (41'(rec_s1.energy) + 41'(kk)) > 41'hFFFFFFFFFF
				? 40'hFFFFFFFFFF : rec_s1.energy + 40'(kk);
		end
	end

	logic last_cpu;
	assign last_cpu = (4'(cpu_q) + 4'd1) == n_mng;

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		cpu_raddr = (state_q == ST_IDLE) ? CpuW'(in_data.cpu_index) : cpu_q;
		if (state_q == ST_IDLE && in_data.opcode == OP_TICK) cpu_raddr = '0;
		// The record read address must follow the walked CPU.
		if (state_q == ST_OUT) cpu_raddr = cpu_q + CpuW'(1);
		ex_raddr = ExW'({cpu_q, 6'd0}) | ExW'(req_q.level_index);
		if (state_q == ST_READ) ex_raddr = ExW'({cpu_q, cpu_rdata.lvl});
		if (state_q == ST_CALC && req_q.opcode != OP_READ)
			ex_raddr = ExW'({cpu_q, rec_s1.lvl});
		cpu_we = 1'b0;
		cpu_waddr = cpu_q;
		cpu_wdata = new_rec;
		ex_we = 1'b0;
		ex_waddr = ExW'({cpu_q, rec_s1.lvl});
		ex_wdata = &ex_rdata ? ex_rdata : ex_rdata + 32'd1;
		if (state_q == ST_CLEAR) begin
			cpu_we = 1'b1;
			cpu_waddr = CpuW'(clr_q);
			cpu_wdata = '0;
			ex_we = 1'b1;
			ex_waddr = ExW'(clr_q);
			ex_wdata = '0;
		end else if (state_q == ST_WRITE) begin
			cpu_we = (req_q.opcode != OP_READ);
			ex_we = ch_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd1;
			up_lim_q <= 20'd5000;
			down_lim_q <= 20'd5000;
			thr_q <= 7'd80;
			boost_q <= 1'b1;
			active_q <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[1:0];
				CFG_UP: up_lim_q <= cfg_data;
				CFG_DOWN: down_lim_q <= cfg_data;
				CFG_THR: thr_q <= cfg_data[6:0];
				CFG_BOOST: boost_q <= cfg_data[0];
				CFG_ACTIVE: active_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) req_q <= in_data;
		if (state_q == ST_READ) begin
			rec_s1 <= rec_in;
			ev_s1 <= do_ev;
			ch_s1 <= do_ev && (tl != cpu_rdata.lvl);
			up_s1 <= tl > cpu_rdata.lvl;
			tgt_s1 <= tl;
		end
		if (state_q == ST_WRITE) begin
			out_data.cpu_out <= 3'(cpu_q);
			out_data.freq_khz <= lvl_to_khz(new_rec.lvl);
			out_data.evaluated <= ev_s1;
			out_data.changed <= ch_s1;
			out_data.switch_count <= new_rec.switches;
			out_data.up_count <= new_rec.ups;
			out_data.down_count <= new_rec.downs;
			out_data.freq_sum_khz <= new_rec.freq_sum;
			out_data.energy_centi <= new_rec.energy;
			out_data.level_exit_count <= (req_q.opcode == OP_READ && lvl_ok) ? ex_rdata : 32'd0;
			out_data.last <= (req_q.opcode != OP_TICK) || last_cpu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cpu_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ClrW'(1);
					if (clr_q == ClrW'(ExDepth - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						cpu_q <= (in_data.opcode == OP_TICK) ? '0 : CpuW'(in_data.cpu_index);
						if ((in_data.opcode == OP_TICK && n_mng != 4'd0) ||
								((in_data.opcode == OP_UTIL || in_data.opcode == OP_READ) &&
								4'(in_data.cpu_index) < n_mng))
							state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_WRITE;
				ST_WRITE: begin
					out_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (req_q.opcode == OP_TICK && !last_cpu) begin
							cpu_q <= cpu_q + CpuW'(1);
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("result outside output state");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall) else $error("request taken during clear");
	a_change_implies_eval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.changed |-> out_data.evaluated) else $error("change without eval");
endmodule

### test/dvfs_util_governor_core_tb.sv
// Self-checking testbench for the utilization governor core.
`timescale 1ns / 1ps
module dvfs_util_governor_core_tb;
	import dug_pkg::*;

	localparam int NCPU = 8;
	localparam int NLVL = 40;
	localparam int IDLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;

	dvfs_util_governor_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Governor state mirrored for prediction.
	logic [1:0] gv_mode;
	logic [19:0] gv_up, gv_down;
	logic [6:0] gv_thr;
	logic gv_boost;
	logic [3:0] gv_active;
	logic [21:0] cur_freq [NCPU];
	logic [6:0] cur_util [NCPU];
	logic [47:0] eval_time [NCPU];
	logic [31:0] sw_cnt [NCPU];
	logic [31:0] up_cnt [NCPU];
	logic [31:0] dn_cnt [NCPU];
	logic [47:0] fsum [NCPU];
	logic [39:0] esum [NCPU];
	logic [31:0] exits [NCPU][NLVL];

	in_item_t pending_reqs[$];
	out_item_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_sender = 0;
	bit in_taken = 0;
	int in_gap = 0;
	int out_gap = 0;

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] sat32(logic [31:0] a);
		return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

	// Recompute the frequency of one CPU; returns 1 on a change.
	function automatic bit reevaluate(int c);
		longint unsigned t, k, s;
		int lvl;
		logic [21:0] old;
		old = cur_freq[c];
		if (cur_util[c] >= gv_thr) begin
			t = cur_util[c] * 40000;
			if (gv_boost) t += 100000;
		end else begin
			t = (cur_util[c] + 10) * 40000;
		end
		t = (t / 100000) * 100000;
		if (t > 4000000) t = 4000000;
		if (t < 800000) t = 800000;
		if (gv_mode == MODE_SAVE && t > 3000000) t = 3000000;
		if (t == old) return 0;
		cur_freq[c] = t[21:0];
		sw_cnt[c] = sat32(sw_cnt[c]);
		if (t > old) up_cnt[c] = sat32(up_cnt[c]);
		else dn_cnt[c] = sat32(dn_cnt[c]);
		lvl = (old - 800000) / 100000;
		if (lvl < NLVL) exits[c][lvl] = sat32(exits[c][lvl]);
		s = fsum[c] + t;
		fsum[c] = (s > 48'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
		k = t / 100000;
		s = esum[c] + k * k;
		esum[c] = (s > 40'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
		return 1;
	endfunction

	function automatic out_item_t status_of(int c, bit ev, bit ch, logic [31:0] ex, bit lst);
		out_item_t o;
		o.cpu_out = c[2:0];
		o.freq_khz = cur_freq[c];
		o.evaluated = ev;
		o.changed = ch;
		o.switch_count = sw_cnt[c];
		o.up_count = up_cnt[c];
		o.down_count = dn_cnt[c];
		o.freq_sum_khz = fsum[c];
		o.energy_centi = esum[c];
		o.level_exit_count = ex;
		o.last = lst;
		return o;
	endfunction

	task automatic predict_governor(in_item_t r);
		int n;
		bit ev, ch;
		logic [31:0] ex;
		n = (gv_active > NCPU) ? NCPU : gv_active;
		case (r.opcode)
			OP_UTIL: if (r.cpu_index < n) begin
				ev = 0;
				ch = 0;
				cur_util[r.cpu_index] = (r.util_percent > 100) ? 7'd100 : r.util_percent[6:0];
				if (48'(r.now_us - eval_time[r.cpu_index]) >= gv_up) begin
					ch = reevaluate(r.cpu_index);
					ev = 1;
					eval_time[r.cpu_index] = r.now_us;
				end
				expected_results.push_back(status_of(r.cpu_index, ev, ch, 0, 1));
			end
			OP_TICK: for (int i = 0; i < n; i++) begin
				ev = 0;
				ch = 0;
				if (48'(r.now_us - eval_time[i]) >= gv_down) begin
					ch = reevaluate(i);
					ev = 1;
					eval_time[i] = r.now_us;
				end
				expected_results.push_back(status_of(i, ev, ch, 0, i + 1 == n));
			end
			OP_READ: if (r.cpu_index < n) begin
				ex = (r.level_index < NLVL) ? exits[r.cpu_index][r.level_index] : 32'd0;
				expected_results.push_back(status_of(r.cpu_index, 0, 0, ex, 1));
			end
			default: ;
		endcase
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Request driver; the monitor flags the rising edge that took the request.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (in_taken) begin
			in_taken = 0;
			in_gap = rand_gap();
			if (in_gap == 0 && !hold_sender && pending_reqs.size() > 0) begin
				in_data <= pending_reqs.pop_front();
			end else begin
				in_valid <= 0;
			end
		end else if (!in_valid) begin
			if (in_gap > 0) in_gap--;
			else if (!hold_sender && pending_reqs.size() > 0) begin
				in_data <= pending_reqs.pop_front();
				in_valid <= 1;
			end
		end
	end

	// Receiver stall pattern.
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1;
		end else begin
			out_stall <= 0;
			if ($urandom_range(0, 9) == 0) out_gap = rand_gap();
		end
	end

	// Monitor: predict on accepted requests, check accepted results.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				predict_governor(in_data);
				in_taken = 1;
				idle_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (out_data !== e) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) idle_cycles = 0;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_MODE: gv_mode = val[1:0];
			CFG_UP: gv_up = val;
			CFG_DOWN: gv_down = val;
			CFG_THR: gv_thr = val[6:0];
			CFG_BOOST: gv_boost = val[0];
			CFG_ACTIVE: gv_active = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic in_item_t mk_req(logic [1:0] op, logic [2:0] c, logic [7:0] u,
			logic [47:0] t, logic [5:0] l);
		in_item_t r;
		r.opcode = op;
		r.cpu_index = c;
		r.util_percent = u;
		r.now_us = t;
		r.level_index = l;
		return r;
	endfunction

	logic [47:0] clock_us;

	// Random phase: mostly advancing time so rate limits pass, some raw noise.
	task automatic random_phase(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 90) clock_us += $urandom_range(0, 3000);
			else clock_us = {$urandom, $urandom};
			r = $urandom_range(0, 99);
			pending_reqs.push_back(mk_req(
				(r < 55) ? OP_UTIL : (r < 75) ? OP_TICK : (r < 97) ? OP_READ : 2'd3,
				$urandom_range(0, 7),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 100),
				clock_us, $urandom_range(0, 63)));
		end
	endtask

	initial begin
		gv_mode = 1; gv_up = 5000; gv_down = 5000; gv_thr = 80; gv_boost = 1; gv_active = 8;
		for (int c = 0; c < NCPU; c++) begin
			cur_freq[c] = 800000; cur_util[c] = 0; eval_time[c] = 0;
			sw_cnt[c] = 0; up_cnt[c] = 0; dn_cnt[c] = 0; fsum[c] = 0; esum[c] = 0;
			for (int l = 0; l < NLVL; l++) exits[c][l] = 0;
		end
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		clock_us = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, every opcode, out-of-range cases.
		write_reg(CFG_UP, 0);
		write_reg(CFG_DOWN, 0);
		pending_reqs.push_back(mk_req(OP_UTIL, 0, 8'd255, 48'd10, 0));
		pending_reqs.push_back(mk_req(OP_UTIL, 1, 8'd0, 48'hFFFF_FFFF_FFFF, 63));
		pending_reqs.push_back(mk_req(OP_UTIL, 7, 8'd79, 48'd20, 0));
		pending_reqs.push_back(mk_req(OP_UTIL, 2, 8'd80, 48'd30, 0));
		pending_reqs.push_back(mk_req(OP_UTIL, 3, 8'd100, 48'd40, 0));
		pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 48'd50, 0));
		pending_reqs.push_back(mk_req(OP_UTIL, 0, 8'd1, 48'd60, 0));
		pending_reqs.push_back(mk_req(OP_READ, 0, 0, 48'd0, 32));
		pending_reqs.push_back(mk_req(OP_READ, 0, 0, 48'd0, 0));
		pending_reqs.push_back(mk_req(OP_READ, 0, 0, 48'd0, 40));
		pending_reqs.push_back(mk_req(OP_READ, 7, 0, 48'd0, 63));
		pending_reqs.push_back(mk_req(2'd3, 5, 8'd200, 48'd70, 5));
		wait_drained();

		write_reg(CFG_MODE, MODE_SAVE);
		write_reg(CFG_THR, 101);
		write_reg(CFG_BOOST, 0);
		write_reg(CFG_ACTIVE, 1);
		pending_reqs.push_back(mk_req(OP_UTIL, 0, 8'd100, 48'd80, 0));
		pending_reqs.push_back(mk_req(OP_UTIL, 5, 8'd100, 48'd90, 0));
		pending_reqs.push_back(mk_req(OP_READ, 3, 0, 48'd0, 0));
		pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 48'd95, 0));
		wait_drained();

		write_reg(CFG_ACTIVE, 0);
		pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 48'd100, 0));
		pending_reqs.push_back(mk_req(OP_UTIL, 0, 8'd50, 48'd110, 0));
		wait_drained();
		write_reg(CFG_ACTIVE, 15);
		write_reg(CFG_UP, 20'hFFFFF);
		write_reg(CFG_DOWN, 20'hFFFFF);
		pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 48'd120, 0));
		pending_reqs.push_back(mk_req(OP_UTIL, 4, 8'd90, 48'd130, 0));
		wait_drained();

		// Random phases across several register settings.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_MODE, $urandom_range(0, 3));
			write_reg(CFG_UP, (ph == 4) ? 20'd1000000 : $urandom_range(0, 4000));
			write_reg(CFG_DOWN, (ph == 4) ? 20'd1000000 : $urandom_range(0, 4000));
			write_reg(CFG_THR, $urandom_range(0, 127));
			write_reg(CFG_BOOST, $urandom_range(0, 1));
			write_reg(CFG_ACTIVE, (ph == 0) ? 8 : $urandom_range(1, 15));
			random_phase(50);
			// Hold the sender until every result is back, then continue.
			while (pending_reqs.size() > 25) @(posedge clk);
			hold_sender = 1;
			while (in_valid || expected_results.size() > 0) @(posedge clk);
			hold_sender = 0;
			random_phase(50);
			wait_drained();
		end
		stim_done = 1;
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
